// ===== design/tlnef_pkg.sv =====
// Package for the text line number and escape filter.
// Holds the shared constants, character codes, register indexes and structs.
// No dependencies.
`default_nettype none

package tlnef_pkg;

	localparam int NUMBER_DIGITS = 6;
	localparam int CNT_BITS      = 4 * NUMBER_DIGITS;
	localparam int PRE_LEN       = NUMBER_DIGITS + 1;
	localparam int BODY_MAX      = 4;
	localparam int MAX_OUT       = PRE_LEN + BODY_MAX;
	localparam int CNT_W         = $clog2(MAX_OUT + 1);
	localparam int CFG_IDX_W     = 3;

	typedef logic [7:0] byte_t;

	localparam byte_t CHR_TAB    = 8'h09;
	localparam byte_t CHR_NL     = 8'h0A;
	localparam byte_t CHR_SPACE  = 8'h20;
	localparam byte_t CHR_DOLLAR = 8'h24;
	localparam byte_t CHR_DASH   = 8'h2D;
	localparam byte_t CHR_ZERO   = 8'h30;
	localparam byte_t CHR_M      = 8'h4D;
	localparam byte_t CHR_CARET  = 8'h5E;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUMBER_NONBLANK  = 3'd0,
		CFG_NUMBER_ALL       = 3'd1,
		CFG_SHOW_ENDS        = 3'd2,
		CFG_SQUEEZE_BLANK    = 3'd3,
		CFG_SHOW_TABS        = 3'd4,
		CFG_SHOW_NONPRINTING = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic number_nonblank;
		logic number_all;
		logic show_ends;
		logic squeeze_blank;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

	// Expansion of one input byte: bytes[0] goes out first.
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0]        count;
	} expn_t;

endpackage

`default_nettype wire

// ===== design/tlnef_ifs.sv =====
// Channel interfaces of the text line number and escape filter:
// input bytes, output bytes and the configuration write channel.
// Depends on tlnef_pkg.
`default_nettype none

interface tlnef_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       file_begin;

	modport source (output valid, output text_byte, output file_begin, input ready);
	modport sink (input valid, input text_byte, input file_begin, output ready);
endinterface

interface tlnef_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

interface tlnef_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tlnef_pkg::CFG_IDX_W-1:0] reg_index;
	logic                           wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== design/tlnef_cfg_regs.sv =====
// Configuration register file of the filter: six one-bit mode flags.
// Depends on tlnef_pkg and tlnef_ifs.
`default_nettype none

module tlnef_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	tlnef_cfg_if.sink         cfg,
	output tlnef_pkg::cfg_t   mode
);
	import tlnef_pkg::*;

	cfg_t mode_q;

	assign cfg.ready = 1'b1;
	assign mode      = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.reg_index)
				CFG_NUMBER_NONBLANK:  mode_q.number_nonblank  <= cfg.wdata;
				CFG_NUMBER_ALL:       mode_q.number_all       <= cfg.wdata;
				CFG_SHOW_ENDS:        mode_q.show_ends        <= cfg.wdata;
				CFG_SQUEEZE_BLANK:    mode_q.squeeze_blank    <= cfg.wdata;
				CFG_SHOW_TABS:        mode_q.show_tabs        <= cfg.wdata;
				CFG_SHOW_NONPRINTING: mode_q.show_nonprinting <= cfg.wdata;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/tlnef_expand.sv =====
// Line state and byte expansion: turns one input byte into its formatted
// output bytes and keeps the line start, blank and BCD line count state.
// Depends on tlnef_pkg.
`default_nettype none

module tlnef_expand (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire tlnef_pkg::cfg_t mode,
	input  wire logic [7:0]   text_byte,
	input  wire logic         file_begin,
	input  wire logic         accept,
	output tlnef_pkg::expn_t  expn
);
	import tlnef_pkg::*;

	logic                at_line_start_q;
	logic                blank_seen_q;
	logic [CNT_BITS-1:0] line_count_q;

	logic                als;
	logic                bs;
	logic [CNT_BITS-1:0] cnt;
	logic                nl;
	logic                is_ctrl;
	logic                caret;
	logic                drop;
	logic                blank_set;
	logic                num_text;
	logic                num_empty;
	logic                pad;
	logic                prefix_num;
	logic                prefix;
	logic                als_next;
	logic                bs_next;
	logic [CNT_BITS-1:0] cnt_next;
	logic                seen_nz;
	logic [3:0]          dig;
	byte_t               pre [PRE_LEN];
	byte_t               bod [BODY_MAX];
	logic [CNT_W-1:0]    blen;
	byte_t               cx;

	// BCD increment that holds at all nines.
	function automatic logic [CNT_BITS-1:0] bcd_inc(input logic [CNT_BITS-1:0] v);
		logic [CNT_BITS-1:0] r;
		logic                carry;
		logic                all9;
		r     = v;
		carry = 1'b1;
		all9  = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (v[4*i +: 4] != 4'd9)
				all9 = 1'b0;
			if (carry) begin
				if (r[4*i +: 4] == 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = r[4*i +: 4] + 4'd1;
					carry       = 1'b0;
				end
			end
		end
		return all9 ? v : r;
	endfunction

	// A new file restarts the line state before its first byte is handled.
	assign als = file_begin ? 1'b1 : at_line_start_q;
	assign bs  = file_begin ? 1'b0 : blank_seen_q;
	assign cnt = file_begin ? CNT_BITS'(1) : line_count_q;

	assign nl      = (text_byte == CHR_NL);
	assign is_ctrl = (text_byte <= 8'd8) || (text_byte >= 8'd11 && text_byte <= 8'd31)
		|| (text_byte >= 8'd127 && text_byte <= 8'd159);
	assign caret   = (mode.show_nonprinting && is_ctrl)
		|| (mode.show_tabs && text_byte == CHR_TAB);

	assign blank_set  = mode.squeeze_blank && als && nl;
	assign drop       = blank_set && bs;
	assign num_text   = !nl && als && (mode.number_nonblank || mode.number_all);
	assign num_empty  = nl && als && mode.number_all && !mode.number_nonblank;
	assign pad        = nl && als && mode.number_nonblank && mode.show_ends;
	assign prefix_num = num_text || num_empty;
	assign prefix     = prefix_num || pad;

	assign cx = (text_byte >= 8'd32) ? text_byte - 8'd64 : text_byte + 8'd64;

	always_comb begin
		seen_nz = 1'b0;
		dig     = 4'd0;
		for (int j = 0; j < NUMBER_DIGITS; j++) begin
			dig = cnt[4*(NUMBER_DIGITS-1-j) +: 4];
			if (dig != 4'd0)
				seen_nz = 1'b1;
			if (pad || (!seen_nz && j < NUMBER_DIGITS - 1))
				pre[j] = CHR_SPACE;
			else
				pre[j] = CHR_ZERO | {4'h0, dig};
		end
		pre[PRE_LEN-1] = CHR_TAB;
	end

	always_comb begin
		for (int k = 0; k < BODY_MAX; k++)
			bod[k] = 8'h00;
		blen = CNT_W'(1);
		if (caret) begin
			if (text_byte > 8'd127) begin
				bod[0] = CHR_M;
				bod[1] = CHR_DASH;
				bod[2] = CHR_CARET;
				bod[3] = cx;
				blen   = CNT_W'(4);
			end else begin
				bod[0] = CHR_CARET;
				bod[1] = cx;
				blen   = CNT_W'(2);
			end
		end else if (nl) begin
			if (mode.show_ends) begin
				bod[0] = CHR_DOLLAR;
				bod[1] = CHR_NL;
				blen   = CNT_W'(2);
			end else begin
				bod[0] = CHR_NL;
			end
		end else begin
			bod[0] = text_byte;
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_OUT; j++) begin
			expn.bytes[j] = 8'h00;
			if (prefix) begin
				if (j < PRE_LEN)
					expn.bytes[j] = pre[j];
				else if (j - PRE_LEN < BODY_MAX)
					expn.bytes[j] = bod[j - PRE_LEN];
			end else if (j < BODY_MAX) begin
				expn.bytes[j] = bod[j];
			end
		end
		if (drop)
			expn.count = '0;
		else
			expn.count = (prefix ? CNT_W'(PRE_LEN) : CNT_W'(0)) + blen;
	end

	always_comb begin
		if (drop) begin
			als_next = als;
			bs_next  = bs;
		end else if (caret) begin
			als_next = 1'b0;
			bs_next  = 1'b0;
		end else if (nl) begin
			als_next = 1'b1;
			bs_next  = bs || blank_set;
		end else begin
			als_next = 1'b0;
			bs_next  = 1'b0;
		end
		cnt_next = (prefix_num && !drop) ? bcd_inc(cnt) : cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			blank_seen_q    <= 1'b0;
			line_count_q    <= CNT_BITS'(1);
		end else if (accept) begin
			at_line_start_q <= als_next;
			blank_seen_q    <= bs_next;
			line_count_q    <= cnt_next;
		end
	end

	// A squeezed newline must come from a line start with a blank already seen.
	a_drop_keeps_blank: assert property (@(posedge clk) disable iff (!arst_n)
		accept && drop |=> blank_seen_q && at_line_start_q)
		else $error("squeezed line left the blank state");

	// Apart from a file start, the line count only moves when a number is printed.
	a_count_moves_on_number: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !file_begin && !prefix_num |=> $stable(line_count_q))
		else $error("line count changed without a printed number");

endmodule

`default_nettype wire

// ===== design/tlnef_serializer.sv =====
// Result register and byte serializer: holds the expansion of one input
// byte and hands it out one beat at a time. Depends on tlnef_pkg, tlnef_ifs.
`default_nettype none

module tlnef_serializer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire tlnef_pkg::expn_t expn,
	input  wire logic         load,
	output logic              load_ok,
	tlnef_out_if.source       dout
);
	import tlnef_pkg::*;

	logic [MAX_OUT-1:0][7:0] buf_s1;
	logic [CNT_W-1:0]        rem_s1;
	logic                    pop;

	assign pop           = dout.valid && dout.ready;
	assign dout.valid    = (rem_s1 != '0);
	assign dout.out_byte = buf_s1[0];
	assign dout.run_last = (rem_s1 == CNT_W'(1));

	// A new item may enter while the last byte of the previous one is taken.
	assign load_ok = (rem_s1 == '0) || (rem_s1 == CNT_W'(1) && dout.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s1 <= '0;
		end else if (load) begin
			rem_s1 <= expn.count;
		end else if (pop) begin
			rem_s1 <= rem_s1 - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			buf_s1 <= expn.bytes;
		else if (pop)
			buf_s1 <= {8'h00, buf_s1[MAX_OUT-1:1]};
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (rem_s1 == '0) || (rem_s1 == CNT_W'(1) && pop))
		else $error("item loaded over pending bytes");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && expn.count != '0 |=> dout.valid && rem_s1 == $past(expn.count))
		else $error("loaded bytes not presented");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_s1 <= CNT_W'(MAX_OUT))
		else $error("pending byte count out of range");

endmodule

`default_nettype wire

// ===== design/text_line_number_escape_filter.sv =====
// The first output byte of an input byte is offered in the cycle after it is accepted.
// Throughput: one input byte per cycle while each yields at most one output byte and the output is ready; a byte
// that yields k output bytes holds the output register for k beats (up to 11).
// Bytes removed by blank-line squeezing are accepted but yield no beat.
// Reset clears all mode flags, sets the line state to line start with count one, no bytes pending.
`default_nettype none

module text_line_number_escape_filter (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tlnef_in_if.sink    din,
	tlnef_out_if.source dout,
	tlnef_cfg_if.sink   cfg
);
	import tlnef_pkg::*;

	cfg_t  mode;
	expn_t expn;
	logic  load_ok;
	logic  accept;

	assign din.ready = load_ok;
	assign accept    = din.valid && load_ok;

	tlnef_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.mode   (mode)
	);

	tlnef_expand u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode),
		.text_byte  (din.text_byte),
		.file_begin (din.file_begin),
		.accept     (accept),
		.expn       (expn)
	);

	tlnef_serializer u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.expn    (expn),
		.load    (accept),
		.load_ok (load_ok),
		.dout    (dout)
	);

endmodule

`default_nettype wire
